FILE: sv/slr_pkg.sv
// Shared constants, FSM state type and small color helpers for the shaded
// line rasterizer. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package slr_pkg;

  localparam int COORD_BITS_DEF = 6;   // default coordinate width
  localparam int COLOR_BITS     = 8;   // one color channel
  localparam int DEPTH_BITS     = 6;   // signed endpoint depth
  localparam int GAIN_BITS      = 4;   // depth_gain register
  localparam int SHADE_BITS     = 10;  // color plus depth offset, signed
  localparam int QUO_BITS       = 8;   // quotient bits of one color division
  localparam int NUM_CH         = 3;   // red, green, blue

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 4'd5;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_START_OUT,
    S_STEP,
    S_DIV,
    S_PIX_OUT
  } state_t;

  // Offset added to an endpoint color: depth * gain for depth <= 0, else 0
  function automatic logic signed [SHADE_BITS-1:0] depth_offset(
      input logic signed [DEPTH_BITS-1:0] d,
      input logic [GAIN_BITS-1:0]         g);
    logic signed [SHADE_BITS:0] p;
    p = d * $signed({1'b0, g});
    if (d > 0) begin
      return '0;
    end
    return p[SHADE_BITS-1:0];
  endfunction

  // Clamp a shaded value to 0..255
  function automatic logic [COLOR_BITS-1:0] sat_color(
      input logic signed [SHADE_BITS-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > $signed(SHADE_BITS'(255))) begin
      return '1;
    end
    return v[COLOR_BITS-1:0];
  endfunction

endpackage

FILE: sv/slr_div.sv
// Restoring divider, one quotient bit per cycle, shared by the three color
// channels. Depends on slr_pkg (QUO_BITS). Quotient must fit in QUO_BITS.
`timescale 1ns / 1ps

module slr_div #(
  parameter int COORD_BITS = slr_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic [COORD_BITS+slr_pkg::QUO_BITS-1:0]  dividend,
  input  logic [COORD_BITS-1:0]                    divisor,
  output logic                                     done,
  output logic [slr_pkg::QUO_BITS-1:0]             quotient
);
  import slr_pkg::*;

  localparam int DW = COORD_BITS + QUO_BITS;
  localparam int CW = $clog2(QUO_BITS);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dsh_r;
  logic [QUO_BITS-1:0] q_r;

  logic          ge;
  assign ge = (rem_r >= dsh_r);

  // Control: busy while the quotient bits are produced, then a one-cycle done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(QUO_BITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  // Datapath: trial subtract of the shifted divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsh_r <= DW'({divisor, {(QUO_BITS-1){1'b0}}});
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_r;
      end
      q_r   <= {q_r[QUO_BITS-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == '0 && !start) |=> done_r)
    else $error("divider did not finish after last bit");

  a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

FILE: sv/shaded_line_rasterizer_unit.sv
// Top level of the shaded line rasterizer: sequencer, Bresenham walker,
// color accumulators and output register. Depends on slr_pkg and slr_div.
`timescale 1ns / 1ps

// Usage
//   in_*  : one line command per transaction (endpoints, depths, colors).
//   out_* : one pixel per transaction, out_tlast on the final pixel.
//   cfg_* : writes depth_gain (4 bits); always ready, write only when idle.
// Each command walks |dx| or |dy| steps along the fast axis. Setup comes
// after the accept (run lengths and shaded colors, then three multiplies of
// the run length by the start colors), and then the start pixel is loaded.
// Each further pixel takes one Bresenham step, three divisions on the one
// shared restoring divider (one quotient bit per cycle), and a pixel load.
// in_tready is high only between commands. A stalled receiver holds the
// pixel in the output register and the sequencer waits before loading the
// next one. Synchronous active-low reset returns to idle, empties the
// output register and sets depth_gain to 5.
module shaded_line_rasterizer_unit #(
  parameter int COORD_BITS = slr_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // start_x, start_y, start_depth, end_x, end_y, end_depth,
  // start_red, start_green, start_blue, end_red, end_green, end_blue
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((4*COORD_BITS+67)/8)*8-1:0]     in_tdata,
  // depth_gain
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [slr_pkg::GAIN_BITS-1:0]          cfg_data,
  // pixel_x, pixel_y, pixel_red, pixel_green, pixel_blue
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((2*COORD_BITS+31)/8)*8-1:0]     out_tdata,
  output logic                                   out_tlast
);
  import slr_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int IN_W  = ((4*CB+67)/8)*8;
  localparam int OUT_W = ((2*CB+31)/8)*8;
  localparam int AW    = CB + SHADE_BITS;       // color accumulator
  localparam int DW    = CB + QUO_BITS;         // divider dividend
  localparam int OFF_SD = 2*CB;
  localparam int OFF_EX = 2*CB + DEPTH_BITS;
  localparam int OFF_EY = 3*CB + DEPTH_BITS;
  localparam int OFF_ED = 4*CB + DEPTH_BITS;
  localparam int OFF_SC = 4*CB + 2*DEPTH_BITS;
  localparam int OFF_EC = OFF_SC + NUM_CH*COLOR_BITS;
  localparam logic [1:0] CH_LAST = 2'(NUM_CH - 1);

  state_t state_r, state_nxt;

  logic [IN_W-1:0]      in_data_r;
  logic [GAIN_BITS-1:0] gain_r;

  logic [CB-1:0]        fast_r, slow_r, t_r, x_r, y_r;
  logic                 x_fast_r, xmv_r, xneg_r, ymv_r, yneg_r;
  logic signed [CB:0]   err_r;
  logic [1:0]           ch_r;
  logic                 pend_r;

  logic signed [SHADE_BITS-1:0] cs_r [NUM_CH];
  logic signed [SHADE_BITS-1:0] ce_r [NUM_CH];
  logic signed [AW-1:0]         acc_r [NUM_CH];
  logic [COLOR_BITS-1:0]        col_r [NUM_CH];

  // Output register
  logic                  out_valid_r, out_last_r;
  logic [CB-1:0]         out_x_r, out_y_r;
  logic [COLOR_BITS-1:0] out_col_r [NUM_CH];

  // Sequencer strobes
  logic slot_free, load_start, load_pix, div_start, last_step;

  // Divider
  logic                div_done;
  logic [QUO_BITS-1:0] div_q;

  // Command fields from the latched transaction
  logic [CB-1:0]                sx, sy, ex, ey;
  logic signed [DEPTH_BITS-1:0] sd, ed;
  logic signed [CB:0]           dx_s, dy_s;
  logic [CB-1:0]                adx, ady;
  logic                         x_fast_c;
  logic signed [SHADE_BITS-1:0] zs, ze;

  assign sx   = in_data_r[0 +: CB];
  assign sy   = in_data_r[CB +: CB];
  assign sd   = $signed(in_data_r[OFF_SD +: DEPTH_BITS]);
  assign ex   = in_data_r[OFF_EX +: CB];
  assign ey   = in_data_r[OFF_EY +: CB];
  assign ed   = $signed(in_data_r[OFF_ED +: DEPTH_BITS]);
  assign dx_s = $signed({1'b0, ex}) - $signed({1'b0, sx});
  assign dy_s = $signed({1'b0, ey}) - $signed({1'b0, sy});

  // Absolute run lengths; y wins a tie
  always_comb begin
    logic signed [CB:0] ax, ay;
    ax = (dx_s < 0) ? -dx_s : dx_s;
    ay = (dy_s < 0) ? -dy_s : dy_s;
    adx = ax[CB-1:0];
    ady = ay[CB-1:0];
  end
  assign x_fast_c = (adx > ady);
  assign zs = depth_offset(sd, gain_r);
  assign ze = depth_offset(ed, gain_r);

  // Bresenham step
  logic signed [CB:0] err_m, err_nxt;
  logic               diag, x_mv, y_mv;
  logic [CB-1:0]      x_nxt, y_nxt;

  assign err_m   = err_r - $signed({1'b0, slow_r});
  assign diag    = (err_m < 0);
  assign err_nxt = diag ? (err_m + $signed({1'b0, fast_r})) : err_m;
  assign x_mv    = xmv_r && (diag || x_fast_r);
  assign y_mv    = ymv_r && (diag || !x_fast_r);
  assign x_nxt   = x_mv ? (xneg_r ? x_r - CB'(1) : x_r + CB'(1)) : x_r;
  assign y_nxt   = y_mv ? (yneg_r ? y_r - CB'(1) : y_r + CB'(1)) : y_r;

  // Run length times start color, one channel per cycle
  logic signed [CB+SHADE_BITS:0] prod;
  assign prod = $signed({1'b0, fast_r}) * cs_r[ch_r];

  assign slot_free = !out_valid_r || out_tready;
  assign last_step = (t_r == fast_r - CB'(1));

  // Next state and strobes
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    load_start = 1'b0;
    load_pix   = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (ch_r == CH_LAST) begin
          state_nxt = S_START_OUT;
        end
      end
      S_START_OUT: begin
        if (slot_free) begin
          load_start = 1'b1;
          state_nxt  = (fast_r == '0) ? S_IDLE : S_STEP;
        end
      end
      S_STEP: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        div_start = !pend_r;
        if (div_done && ch_r == CH_LAST) begin
          state_nxt = S_PIX_OUT;
        end
      end
      S_PIX_OUT: begin
        if (slot_free) begin
          load_pix  = 1'b1;
          state_nxt = last_step ? S_IDLE : S_STEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_valid) begin
      gain_r <= cfg_data;
    end
  end

  // Channel counter and divider handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r   <= '0;
      pend_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_MUL: begin
          ch_r <= (ch_r == CH_LAST) ? 2'd0 : ch_r + 2'd1;
        end
        S_DIV: begin
          if (div_start) begin
            pend_r <= 1'b1;
          end else if (div_done) begin
            pend_r <= 1'b0;
            ch_r   <= (ch_r == CH_LAST) ? 2'd0 : ch_r + 2'd1;
          end
        end
        default: ch_r <= '0;
      endcase
    end
  end

  // Line datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      in_data_r <= in_tdata;
    end
    if (state_r == S_SETUP) begin
      fast_r   <= x_fast_c ? adx : ady;
      slow_r   <= x_fast_c ? ady : adx;
      x_fast_r <= x_fast_c;
      xmv_r    <= (dx_s != 0);
      xneg_r   <= (dx_s < 0);
      ymv_r    <= (dy_s != 0);
      yneg_r   <= (dy_s < 0);
      err_r    <= $signed({1'b0, (x_fast_c ? adx : ady) >> 1});
      x_r      <= sx;
      y_r      <= sy;
      t_r      <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        cs_r[c] <= $signed({2'b00, in_data_r[OFF_SC + c*COLOR_BITS +: COLOR_BITS]}) + zs;
        ce_r[c] <= $signed({2'b00, in_data_r[OFF_EC + c*COLOR_BITS +: COLOR_BITS]}) + ze;
      end
    end
    if (state_r == S_MUL) begin
      acc_r[ch_r] <= $signed(prod[AW-1:0]);
    end
    if (state_r == S_STEP) begin
      err_r <= err_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
    end
    if (state_r == S_DIV && div_done) begin
      col_r[ch_r] <= acc_r[ch_r][AW-1] ? '0 : div_q;
    end
    if (load_pix) begin
      t_r <= t_r + CB'(1);
      for (int c = 0; c < NUM_CH; c++) begin
        acc_r[c] <= acc_r[c] + AW'(ce_r[c] - cs_r[c]);
      end
    end
  end

  slr_div #(
    .COORD_BITS(COORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r[ch_r][DW-1:0]),
    .divisor  (fast_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_start || load_pix) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_start) begin
      out_x_r    <= x_r;
      out_y_r    <= y_r;
      out_last_r <= (fast_r == '0);
      for (int c = 0; c < NUM_CH; c++) begin
        out_col_r[c] <= sat_color(cs_r[c]);
      end
    end else if (load_pix) begin
      out_x_r    <= x_r;
      out_y_r    <= y_r;
      out_last_r <= last_step;
      for (int c = 0; c < NUM_CH; c++) begin
        out_col_r[c] <= col_r[c];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_col_r[2], out_col_r[1], out_col_r[0], out_y_r, out_x_r});

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (load_pix && last_step) |=> state_r == S_IDLE)
    else $error("sequencer kept running after the final pixel");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV && pend_r))
    else $error("divider result outside a pending division");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP) |-> (t_r < fast_r))
    else $error("step index ran past the run length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load_start || load_pix) |-> slot_free)
    else $error("output register overwritten while held");

endmodule
